// File: hw/rtl/skfi_pkg.sv
`timescale 1ns / 1ps

package skfi_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;
  localparam int KEY_BITS_DEFAULT    = 31;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // Per-cell compare results, also handed to the right-hand neighbour.
  typedef struct packed {
    logic at_or_past;   // empty, or stored key >= search key
    logic above;        // occupied and stored key > search key
    logic equal;        // occupied and stored key == search key
    logic first_ap;     // leftmost cell with at_or_past: the insertion slot
    logic first_above;  // leftmost cell with above: holds the next tick
    logic hit;          // the slot cell already holds the key
  } cell_flag_t;

endpackage

// File: hw/rtl/skfi_cell.sv
`timescale 1ns / 1ps

module skfi_cell
  import skfi_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                occupied,
  input  logic [KEY_BITS-1:0] search_key,
  input  logic                insert_en,
  input  logic [KEY_BITS-1:0] left_key,
  input  cell_flag_t          left_flags,
  output logic [KEY_BITS-1:0] stored_key,
  output cell_flag_t          flags
);

  always_comb begin
    flags.at_or_past  = !occupied || (stored_key >= search_key);
    flags.above       = occupied && (stored_key > search_key);
    flags.equal       = occupied && (stored_key == search_key);
    flags.first_ap    = flags.at_or_past && !left_flags.at_or_past;
    flags.first_above = flags.above && !left_flags.above;
    flags.hit         = flags.first_ap && flags.equal;
  end

  // The slot cell takes the search key, every cell past it its left neighbour's key;
  // cells past the fill level may take anything, as they are never read before a write.
  always_ff @(posedge clk) begin
    if (insert_en) begin
      if (flags.first_ap) begin
        stored_key <= search_key;
      end else if (left_flags.at_or_past) begin
        stored_key <= left_key;
      end
    end
  end

endmodule

// File: hw/rtl/skfi_select.sv
`timescale 1ns / 1ps

module skfi_select
  import skfi_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int KEY_BITS    = KEY_BITS_DEFAULT,
  localparam int IDX_BITS   = $clog2(TABLE_DEPTH)
) (
  input  logic [TABLE_DEPTH-1:0] slot_vec,
  input  logic [TABLE_DEPTH-1:0] above_vec,
  input  logic [TABLE_DEPTH-1:0] hit_vec,
  input  logic [KEY_BITS-1:0]    keys [TABLE_DEPTH],
  output logic [IDX_BITS-1:0]    slot_idx,
  output logic                   hit,
  output logic                   any_above,
  output logic [KEY_BITS-1:0]    above_key
);

  // The vectors are one-hot or empty, so plain OR trees do the encoding.
  always_comb begin
    slot_idx  = '0;
    above_key = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_vec[i]) begin
        slot_idx = slot_idx | IDX_BITS'(i);
      end
      if (above_vec[i]) begin
        above_key = above_key | keys[i];
      end
    end
    hit       = |hit_vec;
    any_above = |above_vec;
  end

endmodule

// File: hw/rtl/sorted_key_find_or_insert_core.sv
`timescale 1ns / 1ps
// The start transfer moves the control to the search state, from which the
// result strobe is registered. No new key is taken while busy; the
// search state holds the parallel compare in every cell, the priority encode and
// the shift of the row. The receiver cannot stall: done is high for one cycle.
// Reset clears the fill count, the end-of-measure register and the control.

module sorted_key_find_or_insert_core
  import skfi_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int KEY_BITS    = KEY_BITS_DEFAULT,
  localparam int IDX_BITS   = $clog2(TABLE_DEPTH),
  localparam int CNT_BITS   = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KEY_BITS-1:0] tick,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [KEY_BITS-1:0] cfg_data,
  output logic                done,
  output logic [IDX_BITS-1:0] position,
  output logic                was_inserted,
  output logic                table_full,
  output logic [KEY_BITS-1:0] following_tick
);

  state_t                state;
  state_t                state_next;
  logic [KEY_BITS-1:0]   search_key;
  logic [KEY_BITS-1:0]   end_of_measure;
  logic [CNT_BITS-1:0]   entry_count;
  logic                  insert_en;
  logic                  full_miss;
  logic                  searching;

  logic [KEY_BITS-1:0]    cell_key [TABLE_DEPTH];
  cell_flag_t             cell_flags [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] occupied;
  logic [TABLE_DEPTH-1:0] slot_vec;
  logic [TABLE_DEPTH-1:0] above_vec;
  logic [TABLE_DEPTH-1:0] hit_vec;

  logic [IDX_BITS-1:0]   slot_idx;
  logic                  hit;
  logic                  any_above;
  logic [KEY_BITS-1:0]   above_key;

  assign cfg_ready = 1'b1;
  assign busy      = (state == ST_SEARCH);
  assign searching = (state == ST_SEARCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      search_key <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_of_measure <= '0;
    end else if (cfg_valid && cfg_ready) begin
      end_of_measure <= cfg_data;
    end
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      assign occupied[g]  = (entry_count > CNT_BITS'(g));
      assign slot_vec[g]  = cell_flags[g].first_ap;
      assign above_vec[g] = cell_flags[g].first_above;
      assign hit_vec[g]   = cell_flags[g].hit;

      if (g == 0) begin : g_head
        skfi_cell #(
          .KEY_BITS(KEY_BITS)
        ) u_cell (
          .clk       (clk),
          .occupied  (occupied[g]),
          .search_key(search_key),
          .insert_en (insert_en),
          .left_key  (search_key),
          .left_flags('0),
          .stored_key(cell_key[g]),
          .flags     (cell_flags[g])
        );
      end else begin : g_body
        skfi_cell #(
          .KEY_BITS(KEY_BITS)
        ) u_cell (
          .clk       (clk),
          .occupied  (occupied[g]),
          .search_key(search_key),
          .insert_en (insert_en),
          .left_key  (cell_key[g-1]),
          .left_flags(cell_flags[g-1]),
          .stored_key(cell_key[g]),
          .flags     (cell_flags[g])
        );
      end
    end
  endgenerate

  skfi_select #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_select (
    .slot_vec (slot_vec),
    .above_vec(above_vec),
    .hit_vec  (hit_vec),
    .keys     (cell_key),
    .slot_idx (slot_idx),
    .hit      (hit),
    .any_above(any_above),
    .above_key(above_key)
  );

  assign full_miss = !hit && (entry_count == CNT_BITS'(TABLE_DEPTH));
  assign insert_en = searching && !hit && !full_miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (insert_en) begin
      entry_count <= entry_count + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= searching;
    end
  end

  // The inserted key equals the search key, so the old table already gives
  // the right next tick.
  always_ff @(posedge clk) begin
    if (searching) begin
      position       <= full_miss ? '0 : slot_idx;
      was_inserted   <= !hit && !full_miss;
      table_full     <= full_miss;
      following_tick <= any_above ? above_key : end_of_measure;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_BITS'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    insert_en |=> entry_count == $past(entry_count) + CNT_BITS'(1))
    else $error("insertion did not advance the fill count");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    searching |=> done && !busy)
    else $error("result strobe missing after search cycle");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(was_inserted && table_full))
    else $error("insert and full flags both set");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> entry_count == CNT_BITS'(TABLE_DEPTH))
    else $error("full flag with room left in the table");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import skfi_pkg::*;

  localparam int DEPTH    = TABLE_DEPTH_DEFAULT;
  localparam int KB       = KEY_BITS_DEFAULT;
  localparam int POS_BITS = $clog2(DEPTH);
  localparam logic [KB-1:0] KEY_MAX = {KB{1'b1}};
  localparam int RANDOM_ITEMS = 1130;
  localparam int MAX_PRINTED  = 100;

  typedef struct packed {
    logic [POS_BITS-1:0] position;
    logic                was_inserted;
    logic                table_full;
    logic [KB-1:0]       following_tick;
  } lookup_result_t;

  // Tracks the sorted key table and the results that the block still owes.
  class sorted_key_tracker;
    logic [KB-1:0]  keys [DEPTH];
    int unsigned    fill;
    logic [KB-1:0]  measure_end;
    lookup_result_t awaited_results [$];

    function new();
      fill        = 0;
      measure_end = '0;
    endfunction

    function void set_measure_end(logic [KB-1:0] value);
      measure_end = value;
    endfunction

    // Works out the result of one accepted key and updates the table.
    function void note_key(logic [KB-1:0] key);
      lookup_result_t res;
      int unsigned    slot;
      bit             found;
      slot  = fill;
      found = 0;
      res   = '0;
      for (int i = 0; i < fill; i++) begin
        if (keys[i] >= key) begin
          slot  = i;
          found = (keys[i] == key);
          break;
        end
      end
      if (found) begin
        res.position = slot[POS_BITS-1:0];
      end else if (fill >= DEPTH) begin
        res.table_full = 1'b1;
      end else begin
        for (int i = fill; i > slot; i--) keys[i] = keys[i-1];
        keys[slot]       = key;
        fill             = fill + 1;
        res.position     = slot[POS_BITS-1:0];
        res.was_inserted = 1'b1;
      end
      // The next tick comes from the table as it stands after the step.
      res.following_tick = measure_end;
      for (int i = 0; i < fill; i++) begin
        if (keys[i] > key) begin
          res.following_tick = keys[i];
          break;
        end
      end
      awaited_results = {awaited_results, res};
    endfunction

    // Returns an empty string when the result matches the oldest one awaited.
    function string check_result(lookup_result_t got);
      lookup_result_t exp;
      string          msg;
      msg = "";
      if (awaited_results.size() == 0)
        return $sformatf("result with nothing awaited: pos %0d next %h",
                         got.position, got.following_tick);
      exp = awaited_results.pop_front();
      if (got.position !== exp.position)
        msg = {msg, $sformatf(" position %0d/%0d", got.position, exp.position)};
      if (got.was_inserted !== exp.was_inserted)
        msg = {msg, $sformatf(" was_inserted %b/%b", got.was_inserted, exp.was_inserted)};
      if (got.table_full !== exp.table_full)
        msg = {msg, $sformatf(" table_full %b/%b", got.table_full, exp.table_full)};
      if (got.following_tick !== exp.following_tick)
        msg = {msg, $sformatf(" following_tick %h/%h", got.following_tick,
                              exp.following_tick)};
      if (msg != "") msg = {"got/expected:", msg};
      return msg;
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [KB-1:0]       tick;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [KB-1:0]       cfg_data;
  logic                done;
  logic [POS_BITS-1:0] position;
  logic                was_inserted;
  logic                table_full;
  logic [KB-1:0]       following_tick;

  sorted_key_tracker tracker;
  int unsigned       mismatches;
  int unsigned       keys_sent;

  sorted_key_find_or_insert_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .tick           (tick),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .done           (done),
    .position       (position),
    .was_inserted   (was_inserted),
    .table_full     (table_full),
    .following_tick (following_tick)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTED) $display("[%0t] %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    lookup_result_t got;
    string          msg;
    if (!rst && done) begin
      got = '{position, was_inserted, table_full, following_tick};
      msg = tracker.check_result(got);
      if (msg != "") report_mismatch(msg);
    end
  end

  // Leaves start high after the transfer so that the next key may follow at once.
  task automatic send_key(logic [KB-1:0] key);
    @(negedge clk);
    start = 1'b1;
    tick  = key;
    do @(posedge clk); while (busy);
    tracker.note_key(key);
    keys_sent++;
  endtask

  task automatic pause_sender(int unsigned cycles);
    @(negedge clk);
    start = 1'b0;
    tick  = KB'($urandom());
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    pause_sender(1);
    while (tracker.awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_end_of_measure(logic [KB-1:0] value);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_measure_end(value);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = KB'($urandom());
  endtask

  // Mostly keys already stored, so that the table fills slowly and every
  // position gets found many times; the rest probe neighbours, random keys and extremes.
  function automatic logic [KB-1:0] pick_key();
    int unsigned   r;
    logic [KB-1:0] base;
    r = $urandom_range(99);
    if (tracker.fill != 0)
      base = tracker.keys[$urandom_range(tracker.fill - 1)];
    else
      base = KB'($urandom());
    if (r < 80) return base;
    if (r < 88) return $urandom_range(1) ? base + 1'b1 : base - 1'b1;
    if (r < 96) return KB'($urandom());
    case ($urandom_range(3))
      0:       return '0;
      1:       return KEY_MAX;
      2:       return KB'(1);
      default: return KEY_MAX - 1'b1;
    endcase
  endfunction

  task automatic run_random(int unsigned count);
    int unsigned target;
    int unsigned burst;
    target = keys_sent + count;
    while (keys_sent < target) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && keys_sent < target; b++) send_key(pick_key());
      case ($urandom_range(9))
        0, 1, 2: ;
        3:       drain_results();
        default: pause_sender($urandom_range(1, 8));
      endcase
    end
  endtask

  initial begin
    logic [KB-1:0] measure_ends [4];
    tracker    = new();
    mismatches = 0;
    keys_sent  = 0;
    rst        = 1'b1;
    start      = 1'b0;
    tick       = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // End of measure still at its reset value of zero.
    send_key('0);
    send_key(KEY_MAX);
    send_key('0);
    pause_sender(3);
    send_key(KEY_MAX);
    write_end_of_measure(KEY_MAX);
    send_key(KEY_MAX);
    send_key(KB'(32'h4000_0000));
    send_key(KB'(32'h3FFF_FFFF));
    send_key(KB'(32'h4000_0001));
    send_key(KB'(1));
    send_key(KB'(32'h5555_5555));
    send_key(KB'(32'h2AAA_AAAA));
    send_key(KB'(32'h4000_0000));
    write_end_of_measure(KB'(32'h1234_5678));
    send_key(KEY_MAX - 1'b1);
    send_key(KEY_MAX);
    send_key(KB'(32'h2AAA_AAAB));
    send_key('0);
    send_key(KB'(2));

    measure_ends[0] = KB'($urandom());
    measure_ends[1] = '0;
    measure_ends[2] = KEY_MAX;
    measure_ends[3] = KB'($urandom());
    foreach (measure_ends[p]) begin
      write_end_of_measure(measure_ends[p]);
      run_random(RANDOM_ITEMS / 4);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_key_find_or_insert_core: match");
    end else begin
      $display("sorted_key_find_or_insert_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("sorted_key_find_or_insert_core: mismatch");
    $finish;
  end

endmodule

// File: sorted_key_find_or_insert_core.f
hw/rtl/skfi_pkg.sv
hw/rtl/skfi_cell.sv
hw/rtl/skfi_select.sv
hw/rtl/sorted_key_find_or_insert_core.sv
tb/tb.sv
